/* sv/cte_pkg.sv */
package cte_pkg;

    // Input transaction: two points and the planned course, Q3.28 radians
    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] planned_course;
    } t_cte_in;

    // Output transaction: signed cross track error, Q3.28 radians
    typedef struct packed {
        logic signed [31:0] track_error;
    } t_cte_out;

    // Angle constants in Q28
    localparam logic signed [31:0] PI_Q28      = 32'sd843314857;
    localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
    localparam logic signed [31:0] TWO_PI_Q28  = 32'sd1686629713;

    // Unit value in Q30
    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

    // Start vector of the sine rotation: 1/K in Q40
    localparam logic signed [42:0] SIN_X0 = 43'sd667681662976;

    // Width of the sine argument
    localparam int SIN_AW = 35;

    // arctan(2^-i) in Q28 for the first ten micro-rotations
    localparam logic signed [31:0] ATAN_LO [0:9] = '{
        32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
        32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
        32'sd1048571,   32'sd524287
    };

    // arctan(2^-i) in Q28; past the table it is 2^-i itself
    function automatic logic signed [31:0] atan_q28(input int i);
        logic signed [31:0] r;
        if (i < 10) begin
            r = ATAN_LO[i];
        end else if (i <= 28) begin
            r = 32'sd1 <<< (28 - i);
        end else begin
            r = '0;
        end
        return r;
    endfunction

endpackage

/* sv/cte_stream_if.sv */
interface cte_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/cte_sqrt.sv */
module cte_sqrt #(
    parameter int IW = 63,
    parameter int SW = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [IW-1:0]           i_n,
    input  logic [SW-1:0]           i_side,
    output logic                    o_valid,
    output logic [(IW+1)/2-1:0]     o_root,
    output logic [SW-1:0]           o_side
);
    import cte_pkg::*;

    localparam int RW = (IW + 1) / 2;

    // One root bit per stage, two radicand bits consumed per stage
    logic [RW+1:0]   r_rem  [0:RW-1];
    logic [RW-1:0]   r_q    [0:RW-1];
    logic [2*RW-1:0] r_nn   [0:RW-1];
    logic [SW-1:0]   r_side [0:RW-1];
    logic            r_v    [0:RW-1];

    genvar g;
    for (g = 0; g < RW; g++) begin : g_stage
        logic [RW+1:0]   p_rem;
        logic [RW-1:0]   p_q;
        logic [2*RW-1:0] p_nn;
        logic [SW-1:0]   p_side;
        logic            p_v;
        logic [RW+1:0]   n_shift;
        logic [RW+1:0]   n_trial;

        if (g == 0) begin : g_first
            assign p_rem  = '0;
            assign p_q    = '0;
            assign p_nn   = (2*RW)'(i_n);
            assign p_side = i_side;
            assign p_v    = i_valid;
        end else begin : g_next
            assign p_rem  = r_rem[g-1];
            assign p_q    = r_q[g-1];
            assign p_nn   = r_nn[g-1];
            assign p_side = r_side[g-1];
            assign p_v    = r_v[g-1];
        end

        // Bring down the next bit pair and try the next root bit
        assign n_shift = {p_rem[RW-1:0], p_nn[2*RW-1 -: 2]};
        assign n_trial = {p_q, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (n_shift >= n_trial) begin
                    r_rem[g] <= n_shift - n_trial;
                    r_q[g]   <= {p_q[RW-2:0], 1'b1};
                end else begin
                    r_rem[g] <= n_shift;
                    r_q[g]   <= {p_q[RW-2:0], 1'b0};
                end
                r_nn[g]   <= p_nn << 2;
                r_side[g] <= p_side;
            end
        end
    end

    assign o_valid = r_v[RW-1];
    assign o_root  = r_q[RW-1];
    assign o_side  = r_side[RW-1];

endmodule

/* sv/cte_atan2.sv */
module cte_atan2 #(
    parameter int IW     = 33,
    parameter int SW     = 1,
    parameter int STAGES = 28
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [IW-1:0] i_x,
    input  logic signed [IW-1:0] i_y,
    input  logic [SW-1:0]        i_side,
    output logic                 o_valid,
    output logic signed [31:0]   o_z,
    output logic [SW-1:0]        o_side
);
    import cte_pkg::*;

    localparam int WW = 63;

    // Normalise, first half: shifts of 32, 16 and 8
    logic signed [WW-1:0] n_xe, n_ye, n_x1, n_y1;
    logic [WW-1:0]        n_ax, n_ay, n_m1;

    always_comb begin
        n_xe = WW'(i_x);
        n_ye = WW'(i_y);
        n_ax = n_xe[WW-1] ? WW'(-n_xe) : WW'(n_xe);
        n_ay = n_ye[WW-1] ? WW'(-n_ye) : WW'(n_ye);
        n_m1 = (n_ax > n_ay) ? n_ax : n_ay;
        n_x1 = n_xe;
        n_y1 = n_ye;
        if ((n_m1 >> 27) == '0) begin
            n_m1 = n_m1 << 32; n_x1 = n_x1 <<< 32; n_y1 = n_y1 <<< 32;
        end
        if ((n_m1 >> 43) == '0) begin
            n_m1 = n_m1 << 16; n_x1 = n_x1 <<< 16; n_y1 = n_y1 <<< 16;
        end
        if ((n_m1 >> 51) == '0) begin
            n_m1 = n_m1 << 8; n_x1 = n_x1 <<< 8; n_y1 = n_y1 <<< 8;
        end
    end

    logic                 r1_v, r2_v, r3_v;
    logic signed [WW-1:0] r1_x, r1_y, r2_x, r2_y, r3_x, r3_y;
    logic [WW-1:0]        r1_m;
    logic                 r1_zero, r2_zero, r3_zero;
    logic signed [31:0]   r3_z;
    logic [SW-1:0]        r1_side, r2_side, r3_side;

    // Normalise, second half: shifts of 4, 2 and 1
    logic signed [WW-1:0] n_x2, n_y2;
    logic [WW-1:0]        n_m2;

    always_comb begin
        n_m2 = r1_m;
        n_x2 = r1_x;
        n_y2 = r1_y;
        if ((n_m2 >> 55) == '0) begin
            n_m2 = n_m2 << 4; n_x2 = n_x2 <<< 4; n_y2 = n_y2 <<< 4;
        end
        if ((n_m2 >> 57) == '0) begin
            n_m2 = n_m2 << 2; n_x2 = n_x2 <<< 2; n_y2 = n_y2 <<< 2;
        end
        if ((n_m2 >> 58) == '0) begin
            n_x2 = n_x2 <<< 1; n_y2 = n_y2 <<< 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_x    <= n_x1;
            r1_y    <= n_y1;
            r1_m    <= n_m1;
            r1_zero <= (n_ax == '0) && (n_ay == '0);
            r1_side <= i_side;

            r2_x    <= n_x2;
            r2_y    <= n_y2;
            r2_zero <= r1_zero;
            r2_side <= r1_side;

            // Pre-rotate the left half plane by a quarter turn
            if (r2_x < 0) begin
                if (r2_y >= 0) begin
                    r3_x <= r2_y;
                    r3_y <= -r2_x;
                    r3_z <= HALF_PI_Q28;
                end else begin
                    r3_x <= -r2_y;
                    r3_y <= r2_x;
                    r3_z <= -HALF_PI_Q28;
                end
            end else begin
                r3_x <= r2_x;
                r3_y <= r2_y;
                r3_z <= '0;
            end
            r3_zero <= r2_zero;
            r3_side <= r2_side;
        end
    end

    // Vectoring micro-rotations, one per stage
    logic signed [WW-1:0] r_cx   [0:STAGES-1];
    logic signed [WW-1:0] r_cy   [0:STAGES-1];
    logic signed [31:0]   r_cz   [0:STAGES-1];
    logic                 r_cf   [0:STAGES-1];
    logic [SW-1:0]        r_cs   [0:STAGES-1];
    logic                 r_cv   [0:STAGES-1];

    genvar g;
    for (g = 0; g < STAGES; g++) begin : g_rot
        logic signed [WW-1:0] p_x, p_y;
        logic signed [31:0]   p_z;
        logic                 p_f, p_v;
        logic [SW-1:0]        p_s;

        if (g == 0) begin : g_first
            assign p_x = r3_x;
            assign p_y = r3_y;
            assign p_z = r3_z;
            assign p_f = r3_zero;
            assign p_s = r3_side;
            assign p_v = r3_v;
        end else begin : g_next
            assign p_x = r_cx[g-1];
            assign p_y = r_cy[g-1];
            assign p_z = r_cz[g-1];
            assign p_f = r_cf[g-1];
            assign p_s = r_cs[g-1];
            assign p_v = r_cv[g-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[g] <= 1'b0;
            end else if (i_en) begin
                r_cv[g] <= p_v;
            end
        end

        // Rotate towards the x axis and accumulate the angle
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (p_y >= 0) begin
                    r_cx[g] <= p_x + (p_y >>> g);
                    r_cy[g] <= p_y - (p_x >>> g);
                    r_cz[g] <= p_z + atan_q28(g);
                end else begin
                    r_cx[g] <= p_x - (p_y >>> g);
                    r_cy[g] <= p_y + (p_x >>> g);
                    r_cz[g] <= p_z - atan_q28(g);
                end
                r_cf[g] <= p_f;
                r_cs[g] <= p_s;
            end
        end
    end

    // A zero vector has angle zero
    assign o_valid = r_cv[STAGES-1];
    assign o_z     = r_cf[STAGES-1] ? 32'sd0 : r_cz[STAGES-1];
    assign o_side  = r_cs[STAGES-1];

endmodule

/* sv/cte_sin.sv */
module cte_sin #(
    parameter int STAGES = 28
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic signed [cte_pkg::SIN_AW-1:0] i_a,
    output logic                             o_valid,
    output logic signed [31:0]               o_s
);
    import cte_pkg::*;

    localparam int RED_W = SIN_AW + 1;
    localparam logic [RED_W-1:0] K1   = RED_W'(TWO_PI_Q28);
    localparam logic [RED_W-1:0] K2   = K1 << 1;
    localparam logic [RED_W-1:0] K4   = K1 << 2;
    localparam logic [RED_W-1:0] K8   = K1 << 3;
    localparam logic [RED_W-1:0] K16  = K1 << 4;

    logic               r1_v, r2_v, r3_v, r4_v, r5_v;
    logic [RED_W-1:0]   r1_r, r2_r, r3_r;
    logic signed [31:0] r4_r, r5_r;

    // Reduction modulo 2*pi by restoring subtraction of scaled multiples
    logic [RED_W-1:0]   n_r1, n_r2a, n_r2, n_r3a, n_r3;
    logic signed [31:0] n_r4;

    always_comb begin
        n_r1  = RED_W'(i_a) + K16;
        n_r1  = (n_r1 >= K16) ? n_r1 - K16 : n_r1;
        n_r2a = (r1_r >= K8) ? r1_r - K8 : r1_r;
        n_r2  = (n_r2a >= K4) ? n_r2a - K4 : n_r2a;
        n_r3a = (r2_r >= K2) ? r2_r - K2 : r2_r;
        n_r3  = (n_r3a >= K1) ? n_r3a - K1 : n_r3a;
        n_r4  = signed'({1'b0, r3_r[30:0]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_r <= n_r1;
            r2_r <= n_r2;
            r3_r <= n_r3;
            // Centre on zero
            r4_r <= (n_r4 >= PI_Q28) ? n_r4 - TWO_PI_Q28 : n_r4;
            // Fold into the right half plane
            if (r4_r > HALF_PI_Q28) begin
                r5_r <= PI_Q28 - r4_r;
            end else if (r4_r < -HALF_PI_Q28) begin
                r5_r <= -PI_Q28 - r4_r;
            end else begin
                r5_r <= r4_r;
            end
        end
    end

    // Rotation micro-steps, one per stage
    logic signed [42:0] r_cx [0:STAGES-1];
    logic signed [42:0] r_cy [0:STAGES-1];
    logic signed [31:0] r_cz [0:STAGES-1];
    logic               r_cv [0:STAGES-1];

    genvar g;
    for (g = 0; g < STAGES; g++) begin : g_rot
        logic signed [42:0] p_x, p_y;
        logic signed [31:0] p_z;
        logic               p_v;

        if (g == 0) begin : g_first
            assign p_x = SIN_X0;
            assign p_y = '0;
            assign p_z = r5_r;
            assign p_v = r5_v;
        end else begin : g_next
            assign p_x = r_cx[g-1];
            assign p_y = r_cy[g-1];
            assign p_z = r_cz[g-1];
            assign p_v = r_cv[g-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[g] <= 1'b0;
            end else if (i_en) begin
                r_cv[g] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (p_z >= 0) begin
                    r_cx[g] <= p_x - (p_y >>> g);
                    r_cy[g] <= p_y + (p_x >>> g);
                    r_cz[g] <= p_z - atan_q28(g);
                end else begin
                    r_cx[g] <= p_x + (p_y >>> g);
                    r_cy[g] <= p_y - (p_x >>> g);
                    r_cz[g] <= p_z + atan_q28(g);
                end
            end
        end
    end

    // Round to Q30 and clamp to plus or minus one
    logic               r_f_v;
    logic signed [31:0] r_f_s;
    logic signed [42:0] n_sr;

    assign n_sr = (r_cy[STAGES-1] + 43'sd512) >>> 10;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (i_en) begin
            r_f_v <= r_cv[STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (n_sr > 43'(ONE_Q30)) begin
                r_f_s <= ONE_Q30;
            end else if (n_sr < -43'(ONE_Q30)) begin
                r_f_s <= -ONE_Q30;
            end else begin
                r_f_s <= n_sr[31:0];
            end
        end
    end

    assign o_valid = r_f_v;
    assign o_s     = r_f_s;

endmodule

/* sv/cross_track_error_unit.sv */
// Cross track error of a current point against a planned course, all angles
// in signed Q3.28 radians; a positive result means right of course. The
// block is a fully pipelined datapath and takes one transaction every clock
// cycle while the output stage has room. Most of its depth lies in the two
// 32- and 31-stage square root pipelines and in the two vectoring and the two
// parallel rotation CORDIC pipelines of CORDIC_STAGES stages each. A two-entry
// output stage lets one more transaction in while a result waits; the whole
// pipeline holds only while both entries are full.
module cross_track_error_unit #(
    parameter int CORDIC_STAGES = 28
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cte_stream_if.sink   i_in,
    cte_stream_if.source o_out
);
    import cte_pkg::*;

    logic en;

    // Output and skid registers
    logic               r_out_v, r_skd_v;
    logic signed [31:0] r_out_d, r_skd_d;

    assign en         = !r_skd_v;
    assign i_in.ready = en;

    // Deltas, magnitudes, squares and their sum
    logic               r1_v, r2_v, r3_v, r4_v;
    logic signed [32:0] r1_dx, r1_dy, r2_dx, r2_dy, r3_dx, r3_dy, r4_dx, r4_dy;
    logic signed [31:0] r1_crs, r2_crs, r3_crs, r4_crs;
    logic [30:0]        r2_ux, r2_uy;
    logic               r2_half, r3_half, r4_half;
    logic [61:0]        r3_sx, r3_sy;
    logic [62:0]        r4_sum;
    logic [32:0]        n_ux, n_uy;
    logic               n_half;

    assign n_ux   = r1_dx[32] ? 33'(-r1_dx) : 33'(r1_dx);
    assign n_uy   = r1_dy[32] ? 33'(-r1_dy) : 33'(r1_dy);
    assign n_half = n_ux[32] | n_ux[31] | n_uy[32] | n_uy[31];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_in.valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_dx   <= 33'(i_in.data.pos_x) - 33'(i_in.data.start_x);
            r1_dy   <= 33'(i_in.data.pos_y) - 33'(i_in.data.start_y);
            r1_crs  <= i_in.data.planned_course;

            // Halve both magnitudes when either reaches 2^31
            r2_ux   <= n_half ? n_ux[31:1] : n_ux[30:0];
            r2_uy   <= n_half ? n_uy[31:1] : n_uy[30:0];
            r2_half <= n_half;
            r2_dx   <= r1_dx;
            r2_dy   <= r1_dy;
            r2_crs  <= r1_crs;

            r3_sx   <= r2_ux * r2_ux;
            r3_sy   <= r2_uy * r2_uy;
            r3_half <= r2_half;
            r3_dx   <= r2_dx;
            r3_dy   <= r2_dy;
            r3_crs  <= r2_crs;

            r4_sum  <= 63'(r3_sx) + 63'(r3_sy);
            r4_half <= r3_half;
            r4_dx   <= r3_dx;
            r4_dy   <= r3_dy;
            r4_crs  <= r3_crs;
        end
    end

    // Distance
    logic        sa_v;
    logic [31:0] sa_root;
    logic [98:0] sa_side;
    logic [32:0] ta_dist_in;

    cte_sqrt #(
        .IW (63),
        .SW (99)
    ) u_sqrt_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r4_v),
        .i_n     (r4_sum),
        .i_side  ({r4_half, r4_dx, r4_dy, r4_crs}),
        .o_valid (sa_v),
        .o_root  (sa_root),
        .o_side  (sa_side)
    );

    assign ta_dist_in = sa_side[98] ? {sa_root, 1'b0} : {1'b0, sa_root};

    // Course to the current point
    logic               ta_v;
    logic signed [31:0] ta_z;
    logic [64:0]        ta_side;
    logic [32:0]        ta_dist;
    logic signed [31:0] ta_crs;

    cte_atan2 #(
        .IW     (33),
        .SW     (65),
        .STAGES (CORDIC_STAGES)
    ) u_atan_crs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sa_v),
        .i_x     (signed'(sa_side[97:65])),
        .i_y     (signed'(sa_side[64:32])),
        .i_side  ({ta_dist_in, sa_side[31:0]}),
        .o_valid (ta_v),
        .o_z     (ta_z),
        .o_side  (ta_side)
    );

    assign ta_dist = ta_side[64:32];
    assign ta_crs  = signed'(ta_side[31:0]);

    // Sine arguments: distance and course difference
    logic                     r5_v;
    logic signed [SIN_AW-1:0] r5_a1, r5_a2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (en) begin
            r5_v <= ta_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_a1 <= signed'(SIN_AW'(ta_dist));
            r5_a2 <= SIN_AW'(ta_z) - SIN_AW'(ta_crs);
        end
    end

    logic               s_v;
    logic signed [31:0] s1, s2;

    cte_sin #(
        .STAGES (CORDIC_STAGES)
    ) u_sin_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r5_v),
        .i_a     (r5_a1),
        .o_valid (s_v),
        .o_s     (s1)
    );

    cte_sin #(
        .STAGES (CORDIC_STAGES)
    ) u_sin_diff (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r5_v),
        .i_a     (r5_a2),
        .o_valid (),
        .o_s     (s2)
    );

    // Product of sines, its rounding and the cosine term 1 - p^2
    logic               r6_v, r7_v, r8_v, r9_v;
    logic signed [63:0] r6_prod, r8_pp;
    logic signed [31:0] r7_p, r8_p, r9_p;
    logic [60:0]        r9_n;
    logic signed [63:0] n_pr;

    assign n_pr = (r6_prod + 64'sd536870912) >>> 30;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
            r9_v <= 1'b0;
        end else if (en) begin
            r6_v <= s_v;
            r7_v <= r6_v;
            r8_v <= r7_v;
            r9_v <= r8_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_prod <= s1 * s2;

            if (n_pr > 64'(ONE_Q30)) begin
                r7_p <= ONE_Q30;
            end else if (n_pr < -64'(ONE_Q30)) begin
                r7_p <= -ONE_Q30;
            end else begin
                r7_p <= n_pr[31:0];
            end

            r8_pp <= r7_p * r7_p;
            r8_p  <= r7_p;

            r9_n  <= (61'd1 << 60) - r8_pp[60:0];
            r9_p  <= r8_p;
        end
    end

    // Arcsine as atan2(p, sqrt(1 - p^2))
    logic        sb_v;
    logic [30:0] sb_root;
    logic [31:0] sb_side;

    cte_sqrt #(
        .IW (61),
        .SW (32)
    ) u_sqrt_cos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r9_v),
        .i_n     (r9_n),
        .i_side  (r9_p),
        .o_valid (sb_v),
        .o_root  (sb_root),
        .o_side  (sb_side)
    );

    logic               tb_v;
    logic signed [31:0] tb_z;

    cte_atan2 #(
        .IW     (32),
        .SW     (1),
        .STAGES (CORDIC_STAGES)
    ) u_atan_asin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sb_v),
        .i_x     (signed'({1'b0, sb_root})),
        .i_y     (signed'(sb_side)),
        .i_side  (1'b0),
        .o_valid (tb_v),
        .o_z     (tb_z),
        .o_side  ()
    );

    // Output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_skd_v <= 1'b0;
        end else if (o_out.ready || !r_out_v) begin
            r_out_v <= r_skd_v || (en && tb_v);
            r_skd_v <= 1'b0;
        end else if (en && tb_v) begin
            r_skd_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_out.ready || !r_out_v) begin
            r_out_d <= r_skd_v ? r_skd_d : tb_z;
        end else if (en && tb_v) begin
            r_skd_d <= tb_z;
        end
    end

    assign o_out.valid            = r_out_v;
    assign o_out.data.track_error = r_out_d;

endmodule

/* bench/cte_checker.sv */
`timescale 1ns / 1ps

// Watch both channels, compute the expected track error of each input
// transaction and compare it with the results in order.
module cte_checker #(
    parameter int CORDIC_STAGES = 28
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  cte_pkg::t_cte_in  i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  cte_pkg::t_cte_out i_out_data,
    output int                o_errors,
    output int                o_pending
);
    import cte_pkg::*;

    localparam longint PI_L      = 843314857;
    localparam longint HALF_PI_L = 421657428;
    localparam longint TWO_PI_L  = 1686629713;
    localparam longint ONE_L     = 1073741824;

    logic signed [31:0] track_errors_due [$];
    int errors;

    assign o_errors  = errors;
    assign o_pending = track_errors_due.size();

    // arctan(2^-i) in Q28
    function automatic longint atan_step(input int i);
        longint lo [0:9];
        lo = '{210828714, 124459457, 65760959, 33381290, 16755422,
               8385879, 4193963, 2097109, 1048571, 524287};
        if (i < 10) return lo[i];
        if (i <= 28) return longint'(1) << (28 - i);
        return 0;
    endfunction

    function automatic longint int_sqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n   = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    // Vectoring CORDIC: angle of (x, y) in Q28
    function automatic longint vector_angle(input longint y, input longint x);
        longint ax, ay, m, z, t, nx, ny;
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        m  = ax > ay ? ax : ay;
        z  = 0;
        if (m == 0) return 0;
        while (m < (longint'(1) << 58)) begin
            m = m * 2; x = x * 2; y = y * 2;
        end
        if (x < 0) begin
            if (y >= 0) begin
                t = y; y = -x; x = t; z = HALF_PI_L;
            end else begin
                t = -y; y = x; x = t; z = -HALF_PI_L;
            end
        end
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i); ny = y - (x >>> i); z += atan_step(i);
            end else begin
                nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_step(i);
            end
            x = nx; y = ny;
        end
        return z;
    endfunction

    // Rotation CORDIC sine of any Q28 angle, answered in Q30
    function automatic longint sine_q30(input longint a);
        longint r, x, y, nx, ny, s;
        r = a % TWO_PI_L;
        x = longint'(652032874) * 1024;
        y = 0;
        if (r < 0) r += TWO_PI_L;
        if (r >= PI_L) r -= TWO_PI_L;
        if (r > HALF_PI_L) r = PI_L - r;
        else if (r < -HALF_PI_L) r = -PI_L - r;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (r >= 0) begin
                nx = x - (y >>> i); ny = y + (x >>> i); r -= atan_step(i);
            end else begin
                nx = x + (y >>> i); ny = y - (x >>> i); r += atan_step(i);
            end
            x = nx; y = ny;
        end
        s = (y + 512) >>> 10;
        if (s > ONE_L) s = ONE_L;
        if (s < -ONE_L) s = -ONE_L;
        return s;
    endfunction

    function automatic logic signed [31:0] track_error_of(input t_cte_in t);
        longint dx, dy, ux, uy, span, crs, s1, s2, p, c;
        logic halved;
        dx = longint'(t.pos_x) - longint'(t.start_x);
        dy = longint'(t.pos_y) - longint'(t.start_y);
        ux = dx < 0 ? -dx : dx;
        uy = dy < 0 ? -dy : dy;
        halved = (ux >= 64'h8000_0000) || (uy >= 64'h8000_0000);
        if (halved) begin
            ux = ux >> 1; uy = uy >> 1;
        end
        span = int_sqrt(ux * ux + uy * uy);
        if (halved) span = span * 2;
        crs = vector_angle(dy, dx);
        s1  = sine_q30(span);
        s2  = sine_q30(crs - longint'(t.planned_course));
        p   = (s1 * s2 + (longint'(1) << 29)) >>> 30;
        if (p > ONE_L) p = ONE_L;
        if (p < -ONE_L) p = -ONE_L;
        c = int_sqrt((64'd1 << 60) - p * p);
        return 32'(vector_angle(p, c));
    endfunction

    // Queue predictions on accepted inputs; check each accepted result
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            errors <= 0;
        end else begin
            if (i_in_valid && i_in_ready)
                track_errors_due.push_back(track_error_of(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (track_errors_due.size() == 0) begin
                    $display("%0t: unexpected track_error %0d", $time,
                             i_out_data.track_error);
                    errors <= errors + 1;
                end else if (track_errors_due[0] !== i_out_data.track_error) begin
                    $display("%0t: track_error expected %0d actual %0d", $time,
                             track_errors_due[0], i_out_data.track_error);
                    errors <= errors + 1;
                    void'(track_errors_due.pop_front());
                end else begin
                    void'(track_errors_due.pop_front());
                end
            end
        end
    end

endmodule

/* bench/tb_cross_track_error_unit.sv */
`timescale 1ns / 1ps

module tb_cross_track_error_unit;
    import cte_pkg::*;

    localparam int LATENCY   = 85 + 3 * 28;
    localparam int N_DIRECT  = 22;
    localparam int N_RANDOM  = 1130;
    localparam int CALM_FROM = 950;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;
    int   sent;
    bit   hold_long;
    bit   long_done;
    bit   stim_done;

    cte_stream_if #(.T(t_cte_in))  in_if ();
    cte_stream_if #(.T(t_cte_out)) out_if ();

    cross_track_error_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    cte_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_if.valid),
        .i_in_ready  (in_if.ready),
        .i_in_data   (in_if.data),
        .i_out_valid (out_if.valid),
        .i_out_ready (out_if.ready),
        .i_out_data  (out_if.data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Random angle-like value: mostly moderate, sometimes any bit pattern
    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
            default: return $signed($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
        endcase
    endfunction

    function automatic t_cte_in directed_item(input int k);
        t_cte_in t;
        t = '0;
        case (k)
            0:  ;
            1:  t.planned_course = HALF_PI_Q28;
            2:  t.pos_x = -32'sd1000;
            3:  t.pos_x = 32'sd268435456;
            4:  begin t.pos_y = 32'sd268435456; t.planned_course = PI_Q28; end
            5:  begin t.start_x = 32'h8000_0000; t.pos_x = 32'h7FFF_FFFF; end
            6:  begin t.start_y = 32'h7FFF_FFFF; t.pos_y = 32'h8000_0000; end
            7:  begin t.start_x = 32'h7FFF_FFFF; t.start_y = 32'h7FFF_FFFF;
                      t.pos_x = 32'h8000_0000; t.pos_y = 32'h8000_0000; end
            8:  t.planned_course = 32'h7FFF_FFFF;
            9:  t.planned_course = 32'h8000_0000;
            10: begin t.pos_x = 32'sd100; t.planned_course = -TWO_PI_Q28; end
            11: begin t.pos_y = HALF_PI_Q28; t.planned_course = 32'sd0; end
            12: begin t.pos_x = HALF_PI_Q28; t.planned_course = HALF_PI_Q28; end
            13: begin t.pos_x = -32'sd5; t.pos_y = -32'sd5; end
            14: begin t.pos_x = 32'sd1; end
            15: begin t.pos_y = -32'sd1; t.planned_course = -PI_Q28; end
            16: t = '1;
            17: begin t.pos_x = PI_Q28; t.pos_y = PI_Q28; end
            default: begin
                t.start_x = rand_coord(); t.start_y = rand_coord();
                t.pos_x = rand_coord(); t.pos_y = rand_coord();
                t.planned_course = rand_coord();
            end
        endcase
        return t;
    endfunction

    // Source: offer transactions with random idle bursts
    initial begin
        int gap;
        in_if.valid <= 1'b0;
        in_if.data  <= '0;
        i_rst_n     <= 1'b0;
        stim_done   = 1'b0;
        sent        = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (sent < N_DIRECT + N_RANDOM) begin
            if (sent < CALM_FROM && !hold_long && $urandom_range(0, 5) == 0) begin
                in_if.valid <= 1'b0;
                gap = $urandom_range(1, 10);
                repeat (gap) @(posedge i_clk);
            end
            in_if.valid <= 1'b1;
            in_if.data  <= directed_item(sent < N_DIRECT ? sent : 99);
            @(posedge i_clk);
            while (!in_if.ready) @(posedge i_clk);
            sent++;
        end
        in_if.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Sink: random stall bursts, one long hold-off to fill the pipeline
    initial begin
        int gap;
        out_if.ready <= 1'b0;
        hold_long    = 1'b0;
        long_done    = 1'b0;
        @(posedge i_rst_n);
        while (!stim_done || pending != 0) begin
            if (sent > 300 && !long_done) begin
                long_done = 1'b1;
                hold_long = 1'b1;
                out_if.ready <= 1'b0;
                repeat (600) @(posedge i_clk);
                hold_long = 1'b0;
            end
            if (sent < CALM_FROM && $urandom_range(0, 4) == 0) begin
                out_if.ready <= 1'b0;
                gap = $urandom_range(1, 10);
                repeat (gap) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            @(posedge i_clk);
        end
        out_if.ready <= 1'b1;
        repeat (LATENCY + 20) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("tb_cross_track_error_unit: PASS");
        end else begin
            $display("tb_cross_track_error_unit: FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(12 * 200000);
        $display("tb_cross_track_error_unit: FAIL");
        $finish;
    end

endmodule

/* sim.f */
sv/cte_pkg.sv
sv/cte_stream_if.sv
sv/cte_sqrt.sv
sv/cte_atan2.sv
sv/cte_sin.sv
sv/cross_track_error_unit.sv
bench/cte_checker.sv
bench/tb_cross_track_error_unit.sv
